### src/tdcr_pkg.sv
// Shared constants, types and helper functions for the two-channel down timer.
// Used by every module of the timer; depends on nothing.
package tdcr_pkg;

  localparam int NUM_CHANNELS = 2;
  localparam int PRESCALE_CAP = 4;

  localparam int DATA_W = 32;
  localparam int ADDR_W = 12;
  localparam int REQ_W  = 2;
  localparam int IRQ_W  = 2;
  localparam int HI_W   = 24;
  localparam int INTV_W = DATA_W + HI_W;
  localparam int CNT_W  = INTV_W + PRESCALE_CAP;
  localparam int OFF_W  = 5;
  localparam int PSC_W  = 3;
  localparam int PSC_LSB = 4;

  localparam int IN_TDATA_W  = ((ADDR_W + DATA_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DATA_W + IRQ_W + 7) / 8) * 8;

  // Request kinds.
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd2;

  // Global register offsets and channel window layout.
  localparam logic [ADDR_W-1:0] ADDR_IRQ_EN   = 12'h000;
  localparam logic [ADDR_W-1:0] ADDR_IRQ_STAS = 12'h004;
  localparam int CH_FIRST  = 'h10;
  localparam int CH_STRIDE = 'h20;

  // Register offsets within a channel window.
  localparam logic [OFF_W-1:0] REG_CTRL     = 5'h00;
  localparam logic [OFF_W-1:0] REG_INTV_LO  = 5'h04;
  localparam logic [OFF_W-1:0] REG_INTV_HI  = 5'h08;
  localparam logic [OFF_W-1:0] REG_CURNT_LO = 5'h0C;
  localparam logic [OFF_W-1:0] REG_CURNT_HI = 5'h10;

  // Control word bits.
  localparam int BIT_ENABLE = 0;
  localparam int BIT_RELOAD = 1;
  localparam int BIT_SINGLE = 7;

  typedef struct packed {
    logic              tick;
    logic              ctrl_we;
    logic              lo_we;
    logic              hi_we;
    logic [DATA_W-1:0] wdata;
  } chan_cmd_t;

  typedef struct packed {
    logic              fire;
    logic [DATA_W-1:0] control;
    logic [DATA_W-1:0] intv_lo;
    logic [DATA_W-1:0] intv_hi;
    logic [CNT_W-1:0]  view;
  } chan_stat_t;

  // Period in base ticks: the 56-bit interval shifted by the capped prescale.
  function automatic logic [CNT_W-1:0] period_of(input logic [DATA_W-1:0] ctrl,
                                                 input logic [DATA_W-1:0] lo,
                                                 input logic [DATA_W-1:0] hi);
    logic [PSC_W-1:0]  sh;
    logic [INTV_W-1:0] intv;
    sh = ctrl[PSC_LSB +: PSC_W];
    if (sh > PSC_W'(PRESCALE_CAP)) begin
      sh = PSC_W'(PRESCALE_CAP);
    end
    intv = {hi[HI_W-1:0], lo};
    return CNT_W'(intv) << sh;
  endfunction

endpackage

### src/tdcr_chan.sv
// One timer channel: control, interval, running flag and remaining count.
// Depends on tdcr_pkg for widths, control bits and the period function.
module tdcr_chan import tdcr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  chan_cmd_t  cmd,
  output chan_stat_t stat
);

  logic [DATA_W-1:0] control, control_next;
  logic [DATA_W-1:0] intv_lo, intv_lo_next;
  logic [DATA_W-1:0] intv_hi, intv_hi_next;
  logic              running, running_next;
  logic [CNT_W-1:0]  count, count_next;

  logic [CNT_W-1:0] period_tick;
  logic [CNT_W-1:0] period_wr;
  logic [CNT_W-1:0] cnt_dec;
  logic             fire;

  assign period_tick = period_of(control, intv_lo, intv_hi);
  assign period_wr   = period_of(cmd.wdata, intv_lo, intv_hi);
  assign cnt_dec     = (count != '0) ? count - CNT_W'(1) : count;
  assign fire        = cmd.tick && running && (cnt_dec == '0);

  always_comb begin
    control_next = control;
    intv_lo_next = intv_lo;
    intv_hi_next = intv_hi;
    running_next = running;
    count_next   = count;
    if (cmd.tick && running) begin
      count_next = cnt_dec;
      if (fire) begin
        if (control[BIT_SINGLE]) begin
          running_next = 1'b0;
          control_next[BIT_ENABLE] = 1'b0;
        end else begin
          // Re-arm from the stored control word; a zero period stops the channel.
          running_next = (period_tick != '0);
          count_next   = period_tick;
        end
      end
    end
    if (cmd.ctrl_we) begin
      control_next = cmd.wdata;
      if (cmd.wdata[BIT_ENABLE] && cmd.wdata[BIT_RELOAD]) begin
        running_next = (period_wr != '0);
        count_next   = period_wr;
      end else if (!cmd.wdata[BIT_ENABLE] && control[BIT_ENABLE]) begin
        running_next = 1'b0;
        count_next   = '0;
      end
    end
    if (cmd.lo_we) begin
      intv_lo_next = cmd.wdata;
    end
    if (cmd.hi_we) begin
      intv_hi_next = cmd.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control <= '0;
      intv_lo <= '0;
      intv_hi <= '0;
      running <= 1'b0;
      count   <= '0;
    end else begin
      control <= control_next;
      intv_lo <= intv_lo_next;
      intv_hi <= intv_hi_next;
      running <= running_next;
      count   <= count_next;
    end
  end

  assign stat.fire    = fire;
  assign stat.control = control;
  assign stat.intv_lo = intv_lo;
  assign stat.intv_hi = intv_hi;
  assign stat.view    = running ? count : CNT_W'({intv_hi[HI_W-1:0], intv_lo});

endmodule

### src/two_channel_down_timer_regs_unit.sv
// Top level of the two-channel down timer with its 32-bit register window.
// Depends on tdcr_pkg and instantiates one tdcr_chan per channel.
//
//   channel | direction | tdata fields (low bit up)       | tuser
//   --------+-----------+---------------------------------+---------------
//   s_*     | in        | addr[11:0], wdata[43:12], pad   | req_type[1:0]
//   m_*     | out       | rdata[31:0], irq_lines[33:32]   | (none)
//
// Every transfer in gives exactly one transfer out, in order. A transfer lands
// in the input register, the channel and register updates are worked out from
// there, and the result register holds the response. One transfer is taken
// every cycle while m_tready lets the result register drain; the rate is set
// by the state update loop (60-bit decrement plus reload compare).
// Reset (rst, synchronous) clears the valid flags and the channel and interrupt registers and drops m_tvalid.
// When m_tready is low the result is held and the input register fills, after
// which s_tready falls until the result is taken.
module two_channel_down_timer_regs_unit import tdcr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // addr [11:0], wdata [43:12], zero pad above
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // req_type [1:0]
  input  logic [REQ_W-1:0]       s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // rdata [31:0], irq_lines [33:32], zero pad above
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  // Input register.
  logic              in_valid;
  logic [REQ_W-1:0]  in_req;
  logic [ADDR_W-1:0] in_addr;
  logic [DATA_W-1:0] in_wdata;

  // Result register.
  logic              out_valid;
  logic [DATA_W-1:0] out_rdata;
  logic [IRQ_W-1:0]  out_irq;

  // Global interrupt registers.
  logic [IRQ_W-1:0] irq_enable, irq_enable_next;
  logic [IRQ_W-1:0] irq_status, irq_status_next;

  logic advance;
  logic take;
  logic is_tick, is_read, is_write;

  chan_cmd_t         cmd    [NUM_CHANNELS];
  chan_stat_t        stat   [NUM_CHANNELS];
  logic              hit    [NUM_CHANNELS];
  logic [DATA_W-1:0] chan_rd[NUM_CHANNELS];

  logic [IRQ_W-1:0]  fire_vec;
  logic [DATA_W-1:0] rdata;

  // The held item moves on whenever the result register is free or emptying.
  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;
  assign take     = in_valid && advance;

  assign is_tick  = take && (in_req == REQ_TICK);
  assign is_read  = take && (in_req == REQ_READ);
  assign is_write = take && (in_req == REQ_WRITE);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_req   <= s_tuser;
      in_addr  <= s_tdata[ADDR_W-1:0];
      in_wdata <= s_tdata[ADDR_W +: DATA_W];
    end
  end

  // Per-channel address decode, command and readback.
  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
    localparam logic [ADDR_W-1:0] BASE = ADDR_W'(CH_FIRST + c * CH_STRIDE);
    logic [ADDR_W-1:0] off;
    logic [OFF_W-1:0]  reg_off;

    assign off     = in_addr - BASE;
    assign reg_off = off[OFF_W-1:0];
    assign hit[c]  = (in_addr >= BASE) && (off < ADDR_W'(CH_STRIDE));

    assign cmd[c].tick    = is_tick;
    assign cmd[c].ctrl_we = is_write && hit[c] && (reg_off == REG_CTRL);
    assign cmd[c].lo_we   = is_write && hit[c] && (reg_off == REG_INTV_LO);
    assign cmd[c].hi_we   = is_write && hit[c] && (reg_off == REG_INTV_HI);
    assign cmd[c].wdata   = in_wdata;

    always_comb begin
      case (reg_off)
        REG_CTRL:     chan_rd[c] = stat[c].control;
        REG_INTV_LO:  chan_rd[c] = stat[c].intv_lo;
        REG_INTV_HI:  chan_rd[c] = stat[c].intv_hi;
        REG_CURNT_LO: chan_rd[c] = stat[c].view[DATA_W-1:0];
        REG_CURNT_HI: chan_rd[c] = DATA_W'(stat[c].view >> DATA_W);
        default:      chan_rd[c] = '0;
      endcase
    end

    tdcr_chan u_chan (
      .clk  (clk),
      .rst  (rst),
      .cmd  (cmd[c]),
      .stat (stat[c])
    );
  end

  // Read mux: global registers first, then whichever channel window matches.
  always_comb begin
    rdata    = '0;
    fire_vec = '0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      fire_vec[c] = stat[c].fire;
    end
    if (is_read) begin
      if (in_addr == ADDR_IRQ_EN) begin
        rdata = DATA_W'(irq_enable);
      end else if (in_addr == ADDR_IRQ_STAS) begin
        rdata = DATA_W'(irq_status);
      end else begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          if (hit[c]) begin
            rdata = rdata | chan_rd[c];
          end
        end
      end
    end
  end

  // Status bits are set by a channel reaching zero and cleared by writing ones.
  always_comb begin
    irq_enable_next = irq_enable;
    irq_status_next = irq_status | fire_vec;
    if (is_write && (in_addr == ADDR_IRQ_EN)) begin
      irq_enable_next = in_wdata[IRQ_W-1:0];
    end
    if (is_write && (in_addr == ADDR_IRQ_STAS)) begin
      irq_status_next = irq_status & ~in_wdata[IRQ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      irq_enable <= '0;
      irq_status <= '0;
    end else begin
      irq_enable <= irq_enable_next;
      irq_status <= irq_status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_rdata <= rdata;
      out_irq   <= irq_enable_next & irq_status_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_TDATA_W'({out_irq, out_rdata});

endmodule

### src/tdcr_checker.sv
// Port-level checks for the two-channel down timer, bound to its top level.
// Depends on tdcr_pkg for port widths.
module tdcr_checker import tdcr_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  // A stalled result keeps its valid and its data.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // The input side only backs up when the output is blocked.
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled with output free");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // An accepted transfer passes the input and result registers to the output if m_tready does not block it.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) ##1 m_tready |=> m_tvalid)
    else $error("accepted transfer did not produce a result");

endmodule

bind two_channel_down_timer_regs_unit tdcr_checker u_tdcr_checker (.*);

### tb/tb_top.sv
// Self-checking bench for the two-channel down timer: register reads, writes and ticks
// are streamed in while both sides stall at random, and a shadow model predicts every
// response. Depends on tdcr_pkg and two_channel_down_timer_regs_unit.
`timescale 1ns / 1ps

module tb_top;
  import tdcr_pkg::*;

  // Request kind that the block must ignore; the package only names the three real ones.
  localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;
  localparam int LIMIT_CYCLES = 200000;
  localparam int PHASE_ITEMS = 200;
  localparam int DRAIN_CYCLES = 10;

  typedef struct {
    logic [DATA_W-1:0] rdata;
    logic [IRQ_W-1:0]  irq_lines;
  } timer_resp_t;

  // Shadow copy of the timer. Every accepted request updates the shadow state and
  // queues the response it must produce; responses from the block are checked
  // against the head of that queue.
  class timer_shadow;
    logic [DATA_W-1:0] ctrl_q[NUM_CHANNELS];
    logic [DATA_W-1:0] lo_q[NUM_CHANNELS];
    logic [DATA_W-1:0] hi_q[NUM_CHANNELS];
    bit                running_q[NUM_CHANNELS];
    logic [63:0]       left_q[NUM_CHANNELS];
    logic [IRQ_W-1:0]  irq_en;
    logic [IRQ_W-1:0]  irq_st;
    timer_resp_t       resp_due[$];
    int                mismatches;

    function new();
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        ctrl_q[c] = '0;
        lo_q[c] = '0;
        hi_q[c] = '0;
        running_q[c] = 1'b0;
        left_q[c] = '0;
      end
      irq_en = '0;
      irq_st = '0;
      mismatches = 0;
    endfunction

    function logic [63:0] interval(int c);
      return 64'({hi_q[c][HI_W-1:0], lo_q[c]});
    endfunction

    // Load the count with the interval scaled by the prescale, which saturates at the cap.
    // A zero period leaves the channel stopped.
    function void arm(int c);
      int unsigned sh;
      logic [63:0] period;
      sh = int'(ctrl_q[c][PSC_LSB +: PSC_W]);
      if (sh > PRESCALE_CAP) begin
        sh = PRESCALE_CAP;
      end
      period = interval(c) << sh;
      running_q[c] = (period != 0);
      left_q[c] = period;
    endfunction

    function void tick();
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        if (running_q[c]) begin
          if (left_q[c] != 0) begin
            left_q[c] = left_q[c] - 1;
          end
          if (left_q[c] == 0) begin
            irq_st[c] = 1'b1;
            if (ctrl_q[c][BIT_SINGLE]) begin
              running_q[c] = 1'b0;
              ctrl_q[c][BIT_ENABLE] = 1'b0;
            end else begin
              arm(c);
            end
          end
        end
      end
    endfunction

    function int find_chan(logic [ADDR_W-1:0] a, output logic [OFF_W-1:0] off);
      int base;
      off = '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        base = CH_FIRST + c * CH_STRIDE;
        if (int'(a) >= base && int'(a) < base + CH_STRIDE) begin
          off = OFF_W'(int'(a) - base);
          return c;
        end
      end
      return -1;
    endfunction

    function logic [DATA_W-1:0] read_reg(logic [ADDR_W-1:0] a);
      logic [OFF_W-1:0] off;
      logic [63:0] view;
      int c;
      if (a == ADDR_IRQ_EN) begin
        return DATA_W'(irq_en);
      end
      if (a == ADDR_IRQ_STAS) begin
        return DATA_W'(irq_st);
      end
      c = find_chan(a, off);
      if (c < 0) begin
        return '0;
      end
      // Count readback shows the remaining ticks while running, else the interval.
      view = running_q[c] ? left_q[c] : interval(c);
      case (off)
        REG_CTRL:     return ctrl_q[c];
        REG_INTV_LO:  return lo_q[c];
        REG_INTV_HI:  return hi_q[c];
        REG_CURNT_LO: return view[31:0];
        REG_CURNT_HI: return view[63:32];
        default:      return '0;
      endcase
    endfunction

    function void write_reg(logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
      logic [OFF_W-1:0] off;
      int c;
      bit was_on;
      if (a == ADDR_IRQ_EN) begin
        irq_en = d[IRQ_W-1:0];
        return;
      end
      if (a == ADDR_IRQ_STAS) begin
        irq_st = irq_st & ~d[IRQ_W-1:0];
        return;
      end
      c = find_chan(a, off);
      if (c < 0) begin
        return;
      end
      case (off)
        REG_CTRL: begin
          was_on = ctrl_q[c][BIT_ENABLE];
          ctrl_q[c] = d;
          if (d[BIT_ENABLE] && d[BIT_RELOAD]) begin
            arm(c);
          end else if (!d[BIT_ENABLE] && was_on) begin
            running_q[c] = 1'b0;
            left_q[c] = '0;
          end
        end
        REG_INTV_LO: lo_q[c] = d;
        REG_INTV_HI: hi_q[c] = d;
        default: ;
      endcase
    endfunction

    function void take_request(logic [REQ_W-1:0] kind, logic [ADDR_W-1:0] a,
                               logic [DATA_W-1:0] d);
      timer_resp_t r;
      r.rdata = '0;
      case (kind)
        REQ_TICK:  tick();
        REQ_READ:  r.rdata = read_reg(a);
        REQ_WRITE: write_reg(a, d);
        default: ;
      endcase
      r.irq_lines = irq_en & irq_st;
      resp_due.push_back(r);
    endfunction

    function void check_response(logic [DATA_W-1:0] rdata, logic [IRQ_W-1:0] irq_lines);
      timer_resp_t r;
      if (resp_due.size() == 0) begin
        $display("%0t: response with none expected, rdata %h irq_lines %h",
                 $time, rdata, irq_lines);
        mismatches++;
        return;
      end
      r = resp_due.pop_front();
      if (rdata !== r.rdata) begin
        $display("%0t: rdata expected %h, actual %h", $time, r.rdata, rdata);
        mismatches++;
      end
      if (irq_lines !== r.irq_lines) begin
        $display("%0t: irq_lines expected %h, actual %h", $time, r.irq_lines, irq_lines);
        mismatches++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [REQ_W-1:0]       s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  timer_shadow shadow;
  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int stim_count = 0;
  int cycle_count = 0;

  two_channel_down_timer_regs_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: the slowest legal run stays far below this.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver side: drop tready at random according to the current phase.
  always @(posedge clk) begin
    m_tready <= !rst && ($urandom_range(99) >= sink_idle_pct);
  end

  // Both handshakes are sampled here, at the edge where they complete. Requests are
  // noted before responses so a same-edge pair is always in the right order.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        shadow.take_request(s_tuser, s_tdata[ADDR_W-1:0], s_tdata[ADDR_W +: DATA_W]);
      end
      if (m_tvalid && m_tready) begin
        shadow.check_response(m_tdata[DATA_W-1:0], m_tdata[DATA_W +: IRQ_W]);
      end
    end
  end

  function automatic logic [ADDR_W-1:0] chan_addr(int c, logic [OFF_W-1:0] off);
    return ADDR_W'(CH_FIRST + c * CH_STRIDE + int'(off));
  endfunction

  function automatic logic [DATA_W-1:0] ctrl_word(bit en, bit rl, int psc, bit single);
    logic [DATA_W-1:0] w;
    w = '0;
    w[BIT_ENABLE] = en;
    w[BIT_RELOAD] = rl;
    w[PSC_LSB +: PSC_W] = PSC_W'(psc);
    w[BIT_SINGLE] = single;
    return w;
  endfunction

  // Presents one request and returns at the edge where it is taken. tvalid is only
  // lowered when the sender decides to idle, so back-to-back transfers keep it high.
  task automatic send_item(input logic [REQ_W-1:0] kind, input logic [ADDR_W-1:0] a,
                           input logic [DATA_W-1:0] d);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= IN_TDATA_W'({d, a});
    s_tuser <= kind;
    @(posedge clk);
    while (!s_tready) begin
      @(posedge clk);
    end
  endtask

  // One scene programs a channel with a short period, then runs mostly ticks mixed
  // with readbacks, status clears and control changes, plus some noise.
  task automatic run_scene();
    logic [OFF_W-1:0] chan_regs[5] = '{REG_CTRL, REG_INTV_LO, REG_INTV_HI,
                                       REG_CURNT_LO, REG_CURNT_HI};
    logic [DATA_W-1:0] w;
    int ch;
    int roll;
    int n;
    ch = $urandom_range(NUM_CHANNELS - 1);
    w = ($urandom_range(19) == 0) ? $urandom() : DATA_W'($urandom_range(1, 6));
    send_item(REQ_WRITE, chan_addr(ch, REG_INTV_LO), w);
    roll = $urandom_range(9);
    // Bits above the 24 used interval bits are stored but must not affect the period.
    w = (roll == 0) ? $urandom() : (roll == 1) ? ($urandom() & 32'hFF00_0000) : '0;
    send_item(REQ_WRITE, chan_addr(ch, REG_INTV_HI), w);
    stim_count += 3;
    if ($urandom_range(3) == 0) begin
      send_item(REQ_WRITE, ADDR_IRQ_EN, $urandom());
      stim_count++;
    end
    w = ($urandom_range(3) == 0) ? $urandom() : '0;
    w[BIT_ENABLE] = ($urandom_range(9) != 0);
    w[BIT_RELOAD] = ($urandom_range(4) != 0);
    w[PSC_LSB +: PSC_W] = $urandom_range(1) ? '0 : PSC_W'($urandom_range(7));
    w[BIT_SINGLE] = 1'($urandom_range(1));
    send_item(REQ_WRITE, chan_addr(ch, REG_CTRL), w);
    n = $urandom_range(4, 40);
    repeat (n) begin
      roll = $urandom_range(99);
      if (roll < 65) begin
        // Ticks carry random address and data, which must be ignored.
        send_item(REQ_TICK, ADDR_W'($urandom()), $urandom());
        stim_count++;
      end else if (roll < 82) begin
        ch = $urandom_range(NUM_CHANNELS - 1);
        case ($urandom_range(6))
          0: send_item(REQ_READ, ADDR_IRQ_EN, $urandom());
          1: send_item(REQ_READ, ADDR_IRQ_STAS, $urandom());
          default: send_item(REQ_READ, chan_addr(ch, chan_regs[$urandom_range(4)]),
                             $urandom());
        endcase
        stim_count++;
      end else if (roll < 90) begin
        send_item(REQ_WRITE, $urandom_range(2) ? ADDR_IRQ_STAS : ADDR_IRQ_EN, $urandom());
        stim_count++;
      end else if (roll < 94) begin
        // Stop a channel or change its bits, mostly without a reload.
        w = $urandom();
        w[BIT_RELOAD] = $urandom_range(3) == 0;
        send_item(REQ_WRITE, chan_addr($urandom_range(NUM_CHANNELS - 1), REG_CTRL), w);
        stim_count++;
      end else begin
        send_item(REQ_W'($urandom_range(1, 3)), ADDR_W'($urandom()), $urandom());
      end
    end
  endtask

  initial begin
    shadow = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Both interrupt enables on, then a periodic fire on channel 0.
    send_item(REQ_WRITE, ADDR_IRQ_EN, 32'hFFFF_FFFF);
    send_item(REQ_WRITE, chan_addr(0, REG_INTV_LO), 32'd2);
    send_item(REQ_WRITE, chan_addr(0, REG_CTRL), ctrl_word(1, 1, 0, 0));
    send_item(REQ_TICK, '0, '0);
    send_item(REQ_TICK, 12'hFFF, 32'hFFFF_FFFF);
    send_item(REQ_READ, chan_addr(0, REG_CURNT_LO), '0);
    send_item(REQ_READ, ADDR_IRQ_STAS, '0);
    send_item(REQ_WRITE, ADDR_IRQ_STAS, 32'h1);
    // Single-shot: fires once, stops and clears its own enable bit.
    send_item(REQ_WRITE, chan_addr(0, REG_CTRL), ctrl_word(1, 1, 0, 1));
    send_item(REQ_TICK, '0, '0);
    send_item(REQ_TICK, '0, '0);
    send_item(REQ_READ, chan_addr(0, REG_CTRL), '0);
    send_item(REQ_READ, chan_addr(0, REG_CURNT_LO), '0);
    // Zero interval with only unused high bits set: arming must leave it stopped.
    send_item(REQ_WRITE, chan_addr(1, REG_INTV_HI), 32'hFF00_0000);
    send_item(REQ_WRITE, chan_addr(1, REG_CTRL), ctrl_word(1, 1, 7, 0));
    send_item(REQ_READ, chan_addr(1, REG_CURNT_HI), '0);
    // Largest interval with a prescale above the cap, then stop it again.
    send_item(REQ_WRITE, chan_addr(1, REG_INTV_HI), 32'hFFFF_FFFF);
    send_item(REQ_WRITE, chan_addr(1, REG_INTV_LO), 32'hFFFF_FFFF);
    send_item(REQ_WRITE, chan_addr(1, REG_CTRL), ctrl_word(1, 1, 7, 0));
    send_item(REQ_READ, chan_addr(1, REG_CURNT_HI), '0);
    send_item(REQ_WRITE, chan_addr(1, REG_CTRL), '0);
    // Unmapped space: far address, count register write, gap and unaligned offset,
    // and the unused request kind.
    send_item(REQ_READ, 12'hFFF, '0);
    send_item(REQ_WRITE, chan_addr(0, REG_CURNT_LO), 32'hFFFF_FFFF);
    send_item(REQ_READ, chan_addr(0, 5'h14), '0);
    send_item(REQ_READ, 12'h011, '0);
    send_item(REQ_NONE, ADDR_IRQ_EN, 32'h0);

    // Random part in three phases: sink-heavy stalls, source-heavy stalls, then none.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 21;
          sink_idle_pct = 61;
        end
        1: begin
          src_idle_pct = 61;
          sink_idle_pct = 21;
        end
        default: begin
          src_idle_pct = 0;
          sink_idle_pct = 0;
        end
      endcase
      n_target: begin
        int target;
        target = stim_count + PHASE_ITEMS;
        while (stim_count < target) begin
          run_scene();
        end
      end
    end
    s_tvalid <= 1'b0;

    while (shadow.resp_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shadow.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### two_channel_down_timer_regs_unit.f
src/tdcr_pkg.sv
src/tdcr_chan.sv
src/two_channel_down_timer_regs_unit.sv
src/tdcr_checker.sv
tb/tb_top.sv
